>>> src/rau_pkg.sv
// Package for the rational arithmetic unit: widths, codes and control types.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int OperandWidth = 32;
    localparam int WideWidth    = 64;
    localparam int CntWidth     = 7;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_ZERODEN = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_GCD_START,
        S_GCD_WAIT,
        S_DIV1_START,
        S_DIV1_WAIT,
        S_DIV2_START,
        S_DIV2_WAIT,
        S_ADD_P,
        S_ADD_Q,
        S_ADD_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [WideWidth-1:0] dividend;
        logic [WideWidth-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [WideWidth-1:0] quot;
        logic [WideWidth-1:0] rem;
    } t_div_rsp;
endpackage

>>> src/rau_divider.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider import rau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [WideWidth-1:0] r_quot, n_quot;
    logic [WideWidth-1:0] r_rem, n_rem;
    logic [WideWidth-1:0] r_dsr;
    logic [CntWidth-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [WideWidth:0]   w_shift;
    logic [WideWidth:0]   w_diff;

    always_comb begin
        w_shift = {r_rem, r_quot[WideWidth-1]};
        w_diff  = w_shift - {1'b0, r_dsr};
        n_quot  = {r_quot[WideWidth-2:0], ~w_diff[WideWidth]};
        n_rem   = w_diff[WideWidth] ? w_shift[WideWidth-1:0] : w_diff[WideWidth-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CntWidth'(WideWidth - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;
endmodule

>>> src/rau_ctrl.sv
// Sequencer: sign handling, products, Euclid gcd and scaling via the shared divider.
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  t_op                    i_op,
    input  logic [OperandWidth-1:0] i_an,
    input  logic [OperandWidth-1:0] i_ad,
    input  logic [OperandWidth-1:0] i_bn,
    input  logic [OperandWidth-1:0] i_bd,
    input  logic                   i_out_taken,
    output logic                   o_busy,
    output logic                   o_out_valid,
    output logic [WideWidth-1:0]   o_num,
    output logic [WideWidth-2:0]   o_den,
    output t_status                o_status,
    output t_div_req               o_div_req,
    input  t_div_rsp               i_div_rsp
);
    localparam logic signed [WideWidth-1:0] MaxPos = {1'b0, {(WideWidth-1){1'b1}}};

    t_state r_state, n_state;
    t_op    r_op;
    logic signed [WideWidth-1:0] r_an, r_bn, r_num, r_p;
    logic        [WideWidth-1:0] r_ad, r_bd, r_den, r_x, r_y, r_l;
    t_status                     r_st;
    logic signed [WideWidth-1:0] w_an, w_ad, w_bn, w_bd, w_swap;
    logic        [WideWidth-1:0] w_mag;
    logic signed [WideWidth-1:0] w_mulout;
    logic signed [OperandWidth:0]     w_ma, w_mb;
    logic signed [2*OperandWidth+1:0] w_prod;
    logic signed [WideWidth:0]   w_sum_x;

    always_comb begin
        w_an = WideWidth'(signed'(i_an));
        w_ad = WideWidth'(signed'(i_ad));
        w_bn = WideWidth'(signed'(i_bn));
        w_bd = WideWidth'(signed'(i_bd));
        if (w_ad < 0) begin
            w_ad = -w_ad;
            w_an = -w_an;
        end
        if (w_bd < 0) begin
            w_bd = -w_bd;
            w_bn = -w_bn;
        end
        w_swap = w_bd;
        if (i_op == OP_SUB) begin
            w_bn = -w_bn;
        end else if (i_op == OP_DIV) begin
            w_bd  = (w_bn < 0) ? -w_bn : w_bn;
            w_bn  = (w_bn < 0) ? -w_swap : w_swap;
        end
    end

    // single shared 33x33 multiplier, all operands fit 33 signed bits
    always_comb begin
        w_ma = r_an[OperandWidth:0];
        w_mb = r_bn[OperandWidth:0];
        unique case (r_state)
            S_MUL2: begin
                w_ma = r_ad[OperandWidth:0];
                w_mb = r_bd[OperandWidth:0];
            end
            S_DIV2_START: begin
                w_ma = r_x[OperandWidth:0];
                w_mb = r_bd[OperandWidth:0];
            end
            S_ADD_P: begin
                w_ma = r_an[OperandWidth:0];
                w_mb = r_y[OperandWidth:0];
            end
            S_ADD_Q: begin
                w_ma = r_bn[OperandWidth:0];
                w_mb = i_div_rsp.quot[OperandWidth:0];
            end
            default: ;
        endcase
        w_prod   = w_ma * w_mb;
        w_mulout = w_prod[WideWidth-1:0];
        w_mag    = (r_num < 0) ? -r_num : r_num;
        w_sum_x  = {r_p[WideWidth-1], r_p} + {r_num[WideWidth-1], r_num};
    end

    always_comb begin
        n_state = r_state;
        o_div_req = '0;
        unique case (r_state)
            S_IDLE:       if (i_start) n_state = (i_ad == '0 || i_bd == '0) ? S_OUT :
                                        (i_op == OP_DIV && i_bn == '0) ? S_OUT :
                                        (i_op == OP_MUL || i_op == OP_DIV) ? S_MUL1 :
                                        S_GCD_START;
            S_MUL1:       n_state = S_MUL2;
            S_MUL2:       n_state = S_GCD_START;
            S_GCD_START:  begin
                if (r_y == '0) begin
                    n_state = (r_op == OP_MUL || r_op == OP_DIV) ? S_DIV1_START : S_DIV1_START;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_x;
                    o_div_req.divisor  = r_y;
                    n_state = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:   if (i_div_rsp.done) n_state = S_GCD_START;
            S_DIV1_START: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = (r_op == OP_MUL || r_op == OP_DIV) ? w_mag : r_ad;
                o_div_req.divisor  = r_x;
                n_state = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:  if (i_div_rsp.done) n_state = S_DIV2_START;
            S_DIV2_START: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = (r_op == OP_MUL || r_op == OP_DIV) ? r_den : w_mulout;
                o_div_req.divisor  = (r_op == OP_MUL || r_op == OP_DIV) ? r_x : r_ad;
                n_state = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:  if (i_div_rsp.done)
                              n_state = (r_op == OP_MUL || r_op == OP_DIV) ? S_OUT : S_ADD_P;
            S_ADD_P:      begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = r_l;
                o_div_req.divisor  = r_bd;
                n_state = S_ADD_Q;
            end
            S_ADD_Q:      if (i_div_rsp.done) n_state = S_ADD_SUM;
            S_ADD_SUM:    n_state = S_OUT;
            S_OUT:        if (i_out_taken) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (i_start) begin
                r_op  <= i_op;
                r_an  <= w_an;
                r_ad  <= w_ad;
                r_bn  <= w_bn;
                r_bd  <= w_bd;
                r_num <= '0;
                r_den <= '0;
                r_st  <= ST_OK;
                r_x   <= w_ad;
                r_y   <= w_bd;
                if (i_ad == '0 || i_bd == '0) r_st <= ST_ZERODEN;
                else if (i_op == OP_DIV && i_bn == '0) r_st <= ST_DIVZERO;
            end
            S_MUL1: r_num <= w_mulout;
            S_MUL2: begin
                r_den <= w_mulout;
                r_x   <= (r_num < 0) ? -r_num : r_num;
                r_y   <= w_mulout;
            end
            S_GCD_START: if (r_y == '0 && r_x == '0) r_x <= 64'd1;
            S_GCD_WAIT: if (i_div_rsp.done) begin
                r_x <= r_y;
                r_y <= i_div_rsp.rem;
            end
            S_DIV1_START: if (!(r_op == OP_MUL || r_op == OP_DIV)) r_l <= '0;
            S_DIV1_WAIT: if (i_div_rsp.done) begin
                if (r_op == OP_MUL || r_op == OP_DIV)
                    r_num <= (r_num < 0) ? -i_div_rsp.quot : i_div_rsp.quot;
                else
                    r_x <= i_div_rsp.quot;
            end
            S_DIV2_START: if (!(r_op == OP_MUL || r_op == OP_DIV)) r_l <= w_mulout;
            S_DIV2_WAIT: if (i_div_rsp.done) begin
                if (r_op == OP_MUL || r_op == OP_DIV) r_den <= i_div_rsp.quot;
                else r_y <= i_div_rsp.quot;
            end
            S_ADD_P: r_p <= w_mulout;
            S_ADD_Q: if (i_div_rsp.done) r_num <= w_mulout;
            S_ADD_SUM: begin
                r_den <= r_l;
                if (w_sum_x > 65'(MaxPos)) r_num <= MaxPos;
                else if (w_sum_x < -65'(MaxPos)) r_num <= -MaxPos;
                else r_num <= w_sum_x[WideWidth-1:0];
            end
            default: ;
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_num       = r_num;
    assign o_den       = r_den[WideWidth-2:0];
    assign o_status    = r_st;
endmodule

>>> src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Result time grows with the gcd steps; add/subtract runs a further divider pass beyond
// multiply/divide, and an error request skips straight to the output state.
// Throughput: one request at a time, set by the shared 64-bit serial divider; the next
// request is accepted from the cycle after the result is taken.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // op[1:0], a_num, a_den, b_num, b_den, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata   // res_num[63:0], res_den[126:64], status[128:127]
);
    t_div_req w_req;
    t_div_rsp w_rsp;
    logic     w_busy, w_ov;
    logic [WideWidth-1:0] w_num;
    logic [WideWidth-2:0] w_den;
    t_status  w_st;

    assign s_axis_tready = !w_busy;

    rau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp)
    );

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_op(t_op'(s_axis_tdata[1:0])),
        .i_an(s_axis_tdata[33:2]),
        .i_ad(s_axis_tdata[65:34]),
        .i_bn(s_axis_tdata[97:66]),
        .i_bd(s_axis_tdata[129:98]),
        .i_out_taken(m_axis_tready),
        .o_busy(w_busy), .o_out_valid(w_ov),
        .o_num(w_num), .o_den(w_den), .o_status(w_st),
        .o_div_req(w_req), .i_div_rsp(w_rsp)
    );

    assign m_axis_tvalid = w_ov;
    assign m_axis_tdata  = {7'd0, w_st, w_den, w_num};
endmodule

>>> src/rau_checker.sv
// Port-level checker for the rational arithmetic unit.
`timescale 1ns / 1ps
module rau_checker import rau_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[128:127] <= ST_ZERODEN) else $error("bad status");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[128:127] != ST_OK) |-> m_axis_tdata[126:0] == '0)
        else $error("error result not zero");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
